[hw/rtl/color_to_alpha_pixel_assert.svh]
// Assertion macros used by the color-to-alpha top-level RTL.
`ifndef COLOR_TO_ALPHA_PIXEL_ASSERT_SVH
`define COLOR_TO_ALPHA_PIXEL_ASSERT_SVH

// Implication checked outside reset.
`define C2A_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2a assertion failed");

// Next-cycle implication, live through reset as well.
`define C2A_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c2a reset assertion failed");

`endif

[hw/rtl/c2a_pkg.sv]
// Types and constants of the color-to-alpha pixel block.
package c2a_pkg;

  localparam int ChCount   = 3;
  localparam int DivStages = 8;
  localparam logic [7:0] FullScale = 8'd255;

  localparam logic [1:0] CFG_KEY_RED   = 2'd0;
  localparam logic [1:0] CFG_KEY_GREEN = 2'd1;
  localparam logic [1:0] CFG_KEY_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  // Winning fraction and the pixel that goes with it.
  typedef struct packed {
    logic                    vld;
    logic [7:0]              n;
    logic [7:0]              d;
    logic [ChCount-1:0][7:0] x;
    logic [7:0]              alpha;
  } pick_t;

  // Side data that rides alongside the dividers.
  typedef struct packed {
    logic [ChCount-1:0][7:0] x;
    logic [ChCount-1:0]      neg;
    logic                    pass;
  } side_t;

endpackage

[hw/rtl/c2a_frac.sv]
// Per-channel fractions and selection of the largest one, three stages.
module c2a_frac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  c2a_pkg::pix_in_t          in_pixel,
  input  logic [2:0][7:0]           key,
  output c2a_pkg::pick_t            pick
);
  import c2a_pkg::*;

  logic [ChCount-1:0][7:0] x_in, n_in, d_in;

  logic                    a_vld_r;
  logic [ChCount-1:0][7:0] a_n_r, a_d_r, a_x_r;
  logic [7:0]              a_alpha_r;

  logic                    b_vld_r;
  logic [ChCount-1:0][7:0] b_n_r, b_d_r, b_x_r;
  logic [7:0]              b_alpha_r;
  logic [15:0]             b_n01_r, b_n10_r, b_n02_r, b_n20_r, b_n12_r, b_n21_r;

  logic g01, g02, g12;
  logic [1:0] sel;
  pick_t pick_r, pick_nxt;

  assign x_in[0] = in_pixel.in_red;
  assign x_in[1] = in_pixel.in_green;
  assign x_in[2] = in_pixel.in_blue;

  always_comb begin
    for (int i = 0; i < ChCount; i++) begin
      if (x_in[i] > key[i]) begin
        n_in[i] = x_in[i] - key[i];
        d_in[i] = FullScale - key[i];
      end else if (x_in[i] < key[i]) begin
        n_in[i] = key[i] - x_in[i];
        d_in[i] = key[i];
      end else begin
        n_in[i] = 8'd0;
        d_in[i] = 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      pick_r.vld <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      pick_r.vld <= pick_nxt.vld;
    end
    a_n_r     <= n_in;
    a_d_r     <= d_in;
    a_x_r     <= x_in;
    a_alpha_r <= in_pixel.in_alpha;

    // cross products for the three pairwise compares
    b_n01_r   <= {8'h00, a_n_r[0]} * {8'h00, a_d_r[1]};
    b_n10_r   <= {8'h00, a_n_r[1]} * {8'h00, a_d_r[0]};
    b_n02_r   <= {8'h00, a_n_r[0]} * {8'h00, a_d_r[2]};
    b_n20_r   <= {8'h00, a_n_r[2]} * {8'h00, a_d_r[0]};
    b_n12_r   <= {8'h00, a_n_r[1]} * {8'h00, a_d_r[2]};
    b_n21_r   <= {8'h00, a_n_r[2]} * {8'h00, a_d_r[1]};
    b_n_r     <= a_n_r;
    b_d_r     <= a_d_r;
    b_x_r     <= a_x_r;
    b_alpha_r <= a_alpha_r;

    pick_r.n     <= pick_nxt.n;
    pick_r.d     <= pick_nxt.d;
    pick_r.x     <= pick_nxt.x;
    pick_r.alpha <= pick_nxt.alpha;
  end

  // red wins only when strictly larger, then green, else blue
  always_comb begin
    g01 = b_n01_r > b_n10_r;
    g02 = b_n02_r > b_n20_r;
    g12 = b_n12_r > b_n21_r;
    if (g01) sel = g02 ? 2'd0 : 2'd2;
    else     sel = g12 ? 2'd1 : 2'd2;
    pick_nxt.vld   = b_vld_r;
    pick_nxt.n     = b_n_r[sel];
    pick_nxt.d     = b_d_r[sel];
    pick_nxt.x     = b_x_r;
    pick_nxt.alpha = b_alpha_r;
  end

  assign pick = pick_r;

endmodule

[hw/rtl/c2a_div.sv]
// Pipelined restoring divider, one quotient bit per stage, 8-bit quotient.
module c2a_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic        out_vld,
  output logic [7:0]  quo,
  output logic        rem_nz
);
  import c2a_pkg::*;

  logic        vld_r [0:DivStages-1];
  logic [15:0] rem_r [0:DivStages-1];
  logic [7:0]  den_r [0:DivStages-1];
  logic [7:0]  quo_r [0:DivStages-1];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic        src_vld;
    logic [15:0] src_rem, trial;
    logic [7:0]  src_den, src_quo;
    logic        ge;

    if (k == 0) begin : g_first
      assign src_vld = in_vld;
      assign src_rem = num;
      assign src_den = den;
      assign src_quo = 8'd0;
    end else begin : g_rest
      assign src_vld = vld_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_den = den_r[k-1];
      assign src_quo = quo_r[k-1];
    end

    assign trial = {8'h00, src_den} << (DivStages - 1 - k);
    assign ge    = src_rem >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
      rem_r[k] <= ge ? (src_rem - trial) : src_rem;
      den_r[k] <= src_den;
      quo_r[k] <= {src_quo[6:0], ge};
    end
  end

  assign out_vld = vld_r[DivStages-1];
  assign quo     = quo_r[DivStages-1];
  assign rem_nz  = |rem_r[DivStages-1];

endmodule

[hw/rtl/color_to_alpha_pixel.sv]
// Color-to-alpha pixel block: key colour removed into transparency.
//
// Usage: raise start with a pixel on in_pixel; busy stays low, so a pixel
// is taken at every edge where start is high, one per clock. Each pixel
// gives one word on out_pixel, marked by out_strobe for a single cycle.
// The receiver cannot stall: words leave at the rate they came in, in
// the same order.
// Pipeline: three stages of fraction build, cross-multiply and selection,
// one stage of scaling products, eight stages of bit-per-stage division
// (four divider lanes side by side) and one output register. The divider
// chain sets the latency; throughput is one pixel per cycle throughout.
// Configuration: cfg_we writes cfg_data into key red, green or blue by
// cfg_index; other indexes are dropped. Write keys only while no pixel is
// in flight.
// Reset (synchronous, rst_n low) clears all valid bits and sets every key
// to 255.
module color_to_alpha_pixel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  c2a_pkg::pix_in_t   in_pixel,
  output logic               out_strobe,
  output c2a_pkg::pix_out_t  out_pixel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import c2a_pkg::*;

  logic [ChCount-1:0][7:0] key_r;
  pick_t                   pick;

  logic                    d_vld_r;
  logic [ChCount-1:0][15:0] d_num_r;
  logic [7:0]              d_den_r;
  logic [15:0]             d_anum_r;
  logic [7:0]              d_aden_r;
  side_t                   d_side_r, side_nxt;
  side_t                   side_r [0:DivStages-1];

  logic [ChCount:0]        q_vld;
  logic [ChCount:0][7:0]   q_quo;
  logic [ChCount:0]        q_rnz;

  logic                    out_strobe_r;
  pix_out_t                out_pixel_r, out_pixel_nxt;
  logic [ChCount-1:0][7:0] col;
  logic [7:0]              ceil_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= {ChCount{FullScale}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_RED:   key_r[0] <= cfg_data;
        CFG_KEY_GREEN: key_r[1] <= cfg_data;
        CFG_KEY_BLUE:  key_r[2] <= cfg_data;
        default:       ;
      endcase
    end
  end

  c2a_frac u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_pixel (in_pixel),
    .key      (key_r),
    .pick     (pick)
  );

  always_comb begin
    for (int i = 0; i < ChCount; i++) begin
      side_nxt.x[i]   = pick.x[i];
      side_nxt.neg[i] = pick.x[i] < key_r[i];
    end
    side_nxt.pass = pick.n == 8'd0;
  end

  // scaling products; the zero-fraction case divides by one to stay defined
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= pick.vld;
    end
    for (int i = 0; i < ChCount; i++) begin
      d_num_r[i] <= {8'h00, (side_nxt.neg[i] ? (key_r[i] - pick.x[i])
                                             : (pick.x[i] - key_r[i]))}
                    * {8'h00, pick.d};
    end
    d_den_r  <= side_nxt.pass ? 8'd1 : pick.n;
    d_anum_r <= {8'h00, pick.n} * {8'h00, pick.alpha};
    d_aden_r <= pick.d;
    d_side_r <= side_nxt;
  end

  for (genvar i = 0; i < ChCount; i++) begin : g_col_div
    c2a_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (d_vld_r),
      .num     (d_num_r[i]),
      .den     (d_den_r),
      .out_vld (q_vld[i]),
      .quo     (q_quo[i]),
      .rem_nz  (q_rnz[i])
    );
  end

  c2a_div u_alpha_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld_r),
    .num     (d_anum_r),
    .den     (d_aden_r),
    .out_vld (q_vld[ChCount]),
    .quo     (q_quo[ChCount]),
    .rem_nz  (q_rnz[ChCount])
  );

  // hold side data in step with the divider lanes
  always_ff @(posedge clk) begin
    side_r[0] <= d_side_r;
    for (int k = 1; k < DivStages; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // below the key the colour rounds toward minus infinity: subtract the ceiling
  always_comb begin
    ceil_q = 8'd0;
    for (int i = 0; i < ChCount; i++) begin
      ceil_q = q_quo[i] + {7'd0, q_rnz[i]};
      if (side_r[DivStages-1].pass) col[i] = side_r[DivStages-1].x[i];
      else if (side_r[DivStages-1].neg[i]) col[i] = key_r[i] - ceil_q;
      else col[i] = key_r[i] + q_quo[i];
    end
    out_pixel_nxt.out_red   = col[0];
    out_pixel_nxt.out_green = col[1];
    out_pixel_nxt.out_blue  = col[2];
    out_pixel_nxt.out_alpha = side_r[DivStages-1].pass ? 8'd0 : q_quo[ChCount];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= q_vld[0];
    end
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_pixel  = out_pixel_r;

`include "color_to_alpha_pixel_assert.svh"

  `C2A_ASSERT_IMP(a_lat_strobe, d_vld_r, ##9 out_strobe_r)
  `C2A_ASSERT_IMP(a_pass_alpha, d_vld_r && d_side_r.pass, ##9 (out_pixel_r.out_alpha == 8'd0))
  `C2A_ASSERT_IMP(a_lanes_even, 1'b1, (q_vld == {(ChCount+1){q_vld[0]}}))
  `C2A_ASSERT_RST(a_rst_quiet, !rst_n, !out_strobe_r)

endmodule
